### src/svcbp_pkg.sv
`default_nettype none

package svcbp_pkg;

	localparam logic [7:0] LABEL_PTR_MASK = 8'hC0;

	localparam logic [15:0] KEY_ALPN = 16'd1;
	localparam logic [15:0] KEY_IPV4 = 16'd4;
	localparam logic [15:0] KEY_ECH  = 16'd5;
	localparam logic [15:0] KEY_IPV6 = 16'd6;

	localparam logic [2:0] KIND_ALPN_START = 3'd0;
	localparam logic [2:0] KIND_ALPN_BYTE  = 3'd1;
	localparam logic [2:0] KIND_IPV4       = 3'd2;
	localparam logic [2:0] KIND_IPV6       = 3'd3;
	localparam logic [2:0] KIND_COMMIT     = 3'd4;
	localparam logic [2:0] KIND_END        = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_POINTER   = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_SHORT     = 2'd3;

	typedef enum logic [4:0] {
		PH_PRIO  = 5'b00001,
		PH_LABEL = 5'b00010,
		PH_SKIP  = 5'b00100,
		PH_HDR   = 5'b01000,
		PH_VAL   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic        v_value;
		logic        v_commit;
		logic        v_end;
		logic [2:0]  kind;
		logic [15:0] key;
		logic [31:0] value;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [15:0] commit_len;
		logic [1:0]  status;
	} res_t;

	function automatic logic known_key(input logic [15:0] k);
		known_key = (k == KEY_ALPN) || (k == KEY_IPV4) || (k == KEY_ECH) || (k == KEY_IPV6);
	endfunction

endpackage

`default_nettype wire

### src/svcb_rdata_param_parser.sv
// Wire-form SVCB/HTTPS record-data parameter parser. One record byte is taken per beat on the
// input channel (last marks the final byte); each byte updates the parser state in the same
// cycle and leaves up to three results (a value result, a parameter commit, a record end) in a
// three-slot result buffer that drains one result per cycle while out_ready is high. A byte that
// causes at most one result is taken every cycle while the consumer keeps up; a byte with more
// results holds the input until the single output port has taken all but one. run_last flags
// the last result of each byte. No clearing pass follows reset; bytes are accepted at once.
`default_nettype none

module svcb_rdata_param_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [2:0]  kind,
	output      logic [15:0] param_key,
	output      logic [31:0] value,
	output      logic [63:0] addr_high,
	output      logic [63:0] addr_low,
	output      logic [1:0]  status,
	output      logic        run_last
);

	svcbp_pkg::res_t res;
	logic        take;
	logic        single;
	logic [2:0]  v_s1;
	logic [2:0]  kind_s1;
	logic [15:0] key_s1;
	logic [31:0] value_s1;
	logic [63:0] hi_s1;
	logic [63:0] lo_s1;
	logic [15:0] clen_s1;
	logic [1:0]  status_s1;

	assign single    = (v_s1 & (v_s1 - 3'd1)) == 3'd0;
	assign out_valid = v_s1 != 3'd0;
	assign in_ready  = !out_valid || (single && out_ready);
	assign take      = in_valid && in_ready;

	svcbp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (take),
		.data_byte (data_byte),
		.last      (last),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 3'd0;
		end else if (take) begin
			v_s1 <= {res.v_end, res.v_commit, res.v_value};
		end else if (out_valid && out_ready) begin
			v_s1 <= v_s1 & (v_s1 - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1   <= res.kind;
			key_s1    <= res.key;
			value_s1  <= res.value;
			hi_s1     <= res.addr_high;
			lo_s1     <= res.addr_low;
			clen_s1   <= res.commit_len;
			status_s1 <= res.status;
		end
	end

	always_comb begin
		kind      = svcbp_pkg::KIND_END;
		param_key = 16'd0;
		value     = 32'd0;
		addr_high = 64'd0;
		addr_low  = 64'd0;
		status    = 2'd0;
		run_last  = 1'b1;
		if (v_s1[0]) begin
			kind      = kind_s1;
			param_key = key_s1;
			value     = value_s1;
			addr_high = hi_s1;
			addr_low  = lo_s1;
			run_last  = v_s1[2:1] == 2'd0;
		end else if (v_s1[1]) begin
			kind      = svcbp_pkg::KIND_COMMIT;
			param_key = key_s1;
			value     = {16'd0, clen_s1};
			run_last  = !v_s1[2];
		end else begin
			status = status_s1;
		end
	end

endmodule

`default_nettype wire

### src/svcbp_core.sv
`default_nettype none

module svcbp_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last,
	output svcbp_pkg::res_t        res
);

	svcbp_pkg::phase_t phase_q, phase_n;
	logic [5:0]  skip_q, skip_n;
	logic [15:0] key_q, key_n;
	logic [15:0] vlen_q, vlen_n;
	logic [15:0] off_q, off_n;
	logic [7:0]  alpn_q, alpn_n;
	logic [63:0] acc0_q, acc0_n;
	logic [63:0] acc1_q, acc1_n;
	logic [1:0]  seen_q, seen_n;
	logic        abort_q, abort_n;
	logic [16:0] id_end;

	always_comb begin
		phase_n = phase_q;
		skip_n  = skip_q;
		key_n   = key_q;
		vlen_n  = vlen_q;
		off_n   = off_q;
		alpn_n  = alpn_q;
		acc0_n  = acc0_q;
		acc1_n  = acc1_q;
		abort_n = abort_q;
		seen_n  = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
		id_end  = {1'b0, off_q} + 17'd1 + {9'd0, data_byte};
		res     = '0;
		res.key = key_q;

		if (!abort_q) begin
			case (phase_q)
				svcbp_pkg::PH_PRIO: begin
					if (seen_n >= 2'd2)
						phase_n = svcbp_pkg::PH_LABEL;
				end
				svcbp_pkg::PH_LABEL: begin
					if (data_byte == 8'd0) begin
						phase_n = svcbp_pkg::PH_HDR;
						skip_n  = 6'd0;
					end else if ((data_byte & svcbp_pkg::LABEL_PTR_MASK) != 8'd0) begin
						abort_n = 1'b1;
					end else begin
						skip_n  = data_byte[5:0];
						phase_n = svcbp_pkg::PH_SKIP;
					end
				end
				svcbp_pkg::PH_SKIP: begin
					skip_n = skip_q - 6'd1;
					if (skip_q == 6'd1)
						phase_n = svcbp_pkg::PH_LABEL;
				end
				svcbp_pkg::PH_HDR: begin
					if (skip_q == 6'd0)
						key_n = {data_byte, 8'd0};
					else if (skip_q == 6'd1)
						key_n = {key_q[15:8], data_byte};
					else if (skip_q == 6'd2)
						vlen_n = {data_byte, 8'd0};
					else
						vlen_n = {vlen_q[15:8], data_byte};
					if (skip_q < 6'd3) begin
						skip_n = skip_q + 6'd1;
					end else begin
						skip_n = 6'd0;
						off_n  = 16'd0;
						alpn_n = 8'd0;
						acc0_n = 64'd0;
						acc1_n = 64'd0;
						if (vlen_n == 16'd0) begin
							res.v_commit   = svcbp_pkg::known_key(key_q);
							res.commit_len = 16'd0;
						end else begin
							phase_n = svcbp_pkg::PH_VAL;
						end
					end
				end
				svcbp_pkg::PH_VAL: begin
					if (key_q == svcbp_pkg::KEY_ALPN) begin
						if (skip_q == 6'd0) begin
							if (alpn_q == 8'd0) begin
								if (id_end > {1'b0, vlen_q}) begin
									skip_n = 6'd1;
								end else begin
									alpn_n      = data_byte;
									res.v_value = 1'b1;
									res.kind    = svcbp_pkg::KIND_ALPN_START;
									res.value   = {24'd0, data_byte};
								end
							end else begin
								alpn_n      = alpn_q - 8'd1;
								res.v_value = 1'b1;
								res.kind    = svcbp_pkg::KIND_ALPN_BYTE;
								res.value   = {24'd0, data_byte};
							end
						end
					end else if (key_q == svcbp_pkg::KEY_IPV4) begin
						acc0_n = {32'd0, acc0_q[23:0], data_byte};
						if (off_q[1:0] == 2'd3) begin
							res.v_value = 1'b1;
							res.kind    = svcbp_pkg::KIND_IPV4;
							res.value   = acc0_n[31:0];
						end
					end else if (key_q == svcbp_pkg::KEY_IPV6) begin
						if (!off_q[3])
							acc0_n = {acc0_q[55:0], data_byte};
						else
							acc1_n = {acc1_q[55:0], data_byte};
						if (off_q[3:0] == 4'd15) begin
							res.v_value   = 1'b1;
							res.kind      = svcbp_pkg::KIND_IPV6;
							res.addr_high = acc0_n;
							res.addr_low  = acc1_n;
						end
					end
					off_n = off_q + 16'd1;
					if (off_n == vlen_q) begin
						res.v_commit   = svcbp_pkg::known_key(key_q);
						res.commit_len = vlen_q;
						phase_n        = svcbp_pkg::PH_HDR;
						skip_n         = 6'd0;
					end
				end
				default: begin
					phase_n = svcbp_pkg::PH_PRIO;
				end
			endcase
		end

		if (last) begin
			res.v_end = 1'b1;
			if (seen_n < 2'd3)
				res.status = svcbp_pkg::ST_SHORT;
			else if (abort_n)
				res.status = svcbp_pkg::ST_POINTER;
			else if (phase_n == svcbp_pkg::PH_VAL)
				res.status = svcbp_pkg::ST_TRUNCATED;
			else
				res.status = svcbp_pkg::ST_OK;
			phase_n = svcbp_pkg::PH_PRIO;
			skip_n  = 6'd0;
			key_n   = 16'd0;
			vlen_n  = 16'd0;
			off_n   = 16'd0;
			alpn_n  = 8'd0;
			acc0_n  = 64'd0;
			acc1_n  = 64'd0;
			seen_n  = 2'd0;
			abort_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= svcbp_pkg::PH_PRIO;
			skip_q  <= 6'd0;
			key_q   <= 16'd0;
			vlen_q  <= 16'd0;
			off_q   <= 16'd0;
			alpn_q  <= 8'd0;
			acc0_q  <= 64'd0;
			acc1_q  <= 64'd0;
			seen_q  <= 2'd0;
			abort_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			key_q   <= key_n;
			vlen_q  <= vlen_n;
			off_q   <= off_n;
			alpn_q  <= alpn_n;
			acc0_q  <= acc0_n;
			acc1_q  <= acc1_n;
			seen_q  <= seen_n;
			abort_q <= abort_n;
		end
	end

endmodule

`default_nettype wire

### src/svcbp_checker.sv
`default_nettype none

module svcbp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  kind,
	input wire logic [15:0] param_key,
	input wire logic [63:0] addr_high,
	input wire logic [63:0] addr_low,
	input wire logic [1:0]  status,
	input wire logic        run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped before accept");

	a_end_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> out_valid)
		else $error("no result after final record byte");

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == svcbp_pkg::KIND_END |-> run_last && param_key == 16'd0)
		else $error("record end not last or carries a key");

	a_status_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != svcbp_pkg::KIND_END |-> status == 2'd0)
		else $error("status set outside record end");

	a_addr_only_ipv6: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != svcbp_pkg::KIND_IPV6 |-> addr_high == 64'd0 && addr_low == 64'd0)
		else $error("address set outside ipv6 result");

endmodule

bind svcb_rdata_param_parser svcbp_checker u_svcbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.param_key (param_key),
	.addr_high (addr_high),
	.addr_low  (addr_low),
	.status    (status),
	.run_last  (run_last)
);

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_BEATS = 250;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} beat_t;

	typedef struct {
		logic [2:0]  kind;
		logic [15:0] key;
		logic [31:0] value;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [1:0]  status;
		logic        run_last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic last = 1'b0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic [2:0] kind;
	logic [15:0] param_key;
	logic [31:0] value;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic [1:0] status;
	logic run_last;

	beat_t pending_beats[$];
	logic [7:0] rec_bytes[$];
	result_t expected_results[$];

	int errors = 0;
	int cycle_cnt = 0;
	int record_cnt = 0;
	int beat_cnt = 0;
	int checked_cnt = 0;
	int end_cnt = 0;
	bit in_taken = 1'b0;

	svcbp_pkg::phase_t pstage;
	logic [15:0] hdr_count;
	logic [15:0] cur_key;
	logic [15:0] val_len;
	logic [15:0] val_off;
	logic [7:0] id_left;
	logic [63:0] acc_hi;
	logic [63:0] acc_lo;
	logic [1:0] seen;
	logic dead;

	svcb_rdata_param_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.param_key(param_key),
		.value(value),
		.addr_high(addr_high),
		.addr_low(addr_low),
		.status(status),
		.run_last(run_last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic clear_parser();
		pstage = svcbp_pkg::PH_PRIO;
		hdr_count = '0;
		cur_key = '0;
		val_len = '0;
		val_off = '0;
		id_left = '0;
		acc_hi = '0;
		acc_lo = '0;
		seen = '0;
		dead = 1'b0;
	endtask

	function automatic result_t mk(logic [2:0] k, logic [15:0] key, logic [31:0] v,
			logic [63:0] hi, logic [63:0] lo, logic [1:0] st);
		result_t r;
		r.kind = k;
		r.key = key;
		r.value = v;
		r.hi = hi;
		r.lo = lo;
		r.status = st;
		r.run_last = 1'b0;
		return r;
	endfunction

	function automatic bit is_known(logic [15:0] k);
		return k == svcbp_pkg::KEY_ALPN || k == svcbp_pkg::KEY_IPV4 ||
			k == svcbp_pkg::KEY_ECH || k == svcbp_pkg::KEY_IPV6;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic fin);
		result_t made[$];
		int room;
		logic [1:0] st;
		if (seen < 2'd3)
			seen++;
		if (!dead) begin
			case (pstage)
				svcbp_pkg::PH_PRIO: begin
					if (seen >= 2'd2)
						pstage = svcbp_pkg::PH_LABEL;
				end
				svcbp_pkg::PH_LABEL: begin
					if (b == 8'h00) begin
						pstage = svcbp_pkg::PH_HDR;
						hdr_count = '0;
					end else if ((b & svcbp_pkg::LABEL_PTR_MASK) != 8'h00) begin
						dead = 1'b1;
					end else begin
						hdr_count = {8'h00, b};
						pstage = svcbp_pkg::PH_SKIP;
					end
				end
				svcbp_pkg::PH_SKIP: begin
					hdr_count--;
					if (hdr_count == 16'd0)
						pstage = svcbp_pkg::PH_LABEL;
				end
				svcbp_pkg::PH_HDR: begin
					case (hdr_count)
						16'd0: cur_key = {b, 8'h00};
						16'd1: cur_key = {cur_key[15:8], b};
						16'd2: val_len = {b, 8'h00};
						default: val_len = {val_len[15:8], b};
					endcase
					if (hdr_count < 16'd3) begin
						hdr_count++;
					end else begin
						hdr_count = '0;
						val_off = '0;
						id_left = '0;
						acc_hi = '0;
						acc_lo = '0;
						if (val_len == 16'd0) begin
							if (is_known(cur_key))
								made.insert(made.size(), mk(svcbp_pkg::KIND_COMMIT,
									cur_key, {16'h0, val_len}, '0, '0,
									svcbp_pkg::ST_OK));
						end else begin
							pstage = svcbp_pkg::PH_VAL;
						end
					end
				end
				svcbp_pkg::PH_VAL: begin
					if (cur_key == svcbp_pkg::KEY_ALPN) begin
						if (hdr_count == 16'd0) begin
							if (id_left == 8'd0) begin
								room = val_off + 1 + b;
								if (room > val_len) begin
									hdr_count = 16'd1;
								end else begin
									id_left = b;
									made.insert(made.size(),
										mk(svcbp_pkg::KIND_ALPN_START, cur_key,
										{24'h0, b}, '0, '0, svcbp_pkg::ST_OK));
								end
							end else begin
								id_left--;
								made.insert(made.size(),
									mk(svcbp_pkg::KIND_ALPN_BYTE, cur_key,
									{24'h0, b}, '0, '0, svcbp_pkg::ST_OK));
							end
						end
					end else if (cur_key == svcbp_pkg::KEY_IPV4) begin
						acc_hi = {32'h0, acc_hi[23:0], b};
						if (val_off[1:0] == 2'd3)
							made.insert(made.size(), mk(svcbp_pkg::KIND_IPV4, cur_key,
								acc_hi[31:0], '0, '0, svcbp_pkg::ST_OK));
					end else if (cur_key == svcbp_pkg::KEY_IPV6) begin
						if (val_off[3:0] < 4'd8)
							acc_hi = {acc_hi[55:0], b};
						else
							acc_lo = {acc_lo[55:0], b};
						if (val_off[3:0] == 4'd15)
							made.insert(made.size(), mk(svcbp_pkg::KIND_IPV6, cur_key,
								'0, acc_hi, acc_lo, svcbp_pkg::ST_OK));
					end
					val_off++;
					if (val_off == val_len) begin
						if (is_known(cur_key))
							made.insert(made.size(), mk(svcbp_pkg::KIND_COMMIT, cur_key,
								{16'h0, val_len}, '0, '0, svcbp_pkg::ST_OK));
						pstage = svcbp_pkg::PH_HDR;
						hdr_count = '0;
					end
				end
				default: pstage = svcbp_pkg::PH_PRIO;
			endcase
		end
		if (fin) begin
			if (seen < 2'd3)
				st = svcbp_pkg::ST_SHORT;
			else if (dead)
				st = svcbp_pkg::ST_POINTER;
			else if (pstage == svcbp_pkg::PH_VAL)
				st = svcbp_pkg::ST_TRUNCATED;
			else
				st = svcbp_pkg::ST_OK;
			made.insert(made.size(), mk(svcbp_pkg::KIND_END, 16'h0, '0, '0, '0, st));
			clear_parser();
		end
		if (made.size() > 0)
			made[made.size() - 1].run_last = 1'b1;
		foreach (made[i])
			expected_results.insert(expected_results.size(), made[i]);
	endtask

	function automatic logic [7:0] rb();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic bit take_idle();
		if (cycle_cnt >= 150 && cycle_cnt < 320)
			return 1'b0;
		return $urandom_range(0, 99) < 28;
	endfunction

	task automatic flush_record(input int keep);
		beat_t bt;
		for (int i = 0; i < keep; i++) begin
			bt.data = rec_bytes[i];
			bt.fin = (i == keep - 1);
			pending_beats.insert(pending_beats.size(), bt);
		end
		beat_cnt += keep;
		record_cnt++;
		rec_bytes.delete();
	endtask

	task automatic add16(input logic [15:0] v);
		rec_bytes.insert(rec_bytes.size(), v[15:8]);
		rec_bytes.insert(rec_bytes.size(), v[7:0]);
	endtask

	task automatic add_labels(input int n);
		int len;
		for (int i = 0; i < n; i++) begin
			len = ($urandom_range(0, 19) == 0) ? 63 : $urandom_range(1, 4);
			rec_bytes.insert(rec_bytes.size(), 8'(len));
			for (int j = 0; j < len; j++)
				rec_bytes.insert(rec_bytes.size(), rb());
		end
	endtask

	task automatic add_param(input bit long_tail);
		logic [7:0] val[$];
		logic [15:0] key;
		logic [15:0] len16;
		int n;
		int len;
		n = 0;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				key = svcbp_pkg::KEY_ALPN;
				for (int i = $urandom_range(1, 3); i > 0; i--) begin
					len = $urandom_range(0, 5);
					val.insert(val.size(), 8'(len));
					for (int j = 0; j < len; j++)
						val.insert(val.size(), rb());
				end
				if ($urandom_range(0, 3) == 0) begin
					val.insert(val.size(), 8'($urandom_range(3, 255)));
					for (int j = $urandom_range(0, 2); j > 0; j--)
						val.insert(val.size(), rb());
				end
			end
			3, 4: begin
				key = svcbp_pkg::KEY_IPV4;
				n = 4 * $urandom_range(1, 2) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			end
			5, 6: begin
				key = svcbp_pkg::KEY_IPV6;
				n = 16 * $urandom_range(1, 2) + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0);
			end
			7: begin
				key = svcbp_pkg::KEY_ECH;
				n = $urandom_range(0, 6);
			end
			8: begin
				key = 16'($urandom_range(7, 65535));
				n = $urandom_range(0, 5);
			end
			default: begin
				key = 16'($urandom_range(0, 3));
				if (key == svcbp_pkg::KEY_ALPN)
					key = 16'd3;
				n = $urandom_range(0, 5);
			end
		endcase
		for (int i = 0; i < n; i++)
			val.insert(val.size(), rb());
		if ($urandom_range(0, 9) == 0)
			val.delete();
		len16 = 16'(val.size());
		if (long_tail)
			len16 = 16'($urandom_range(val.size() + 1, 65535));
		add16(key);
		add16(len16);
		foreach (val[i])
			rec_bytes.insert(rec_bytes.size(), val[i]);
	endtask

	task automatic add_record();
		int r;
		int n;
		int keep;
		bit long_tail;
		long_tail = 1'b0;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			for (n = $urandom_range(1, 2); n > 0; n--)
				rec_bytes.insert(rec_bytes.size(), rb());
		end else if (r < 20) begin
			add16(16'($urandom_range(0, 65535)));
			add_labels($urandom_range(0, 1));
			rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(64, 255)));
			for (n = $urandom_range(0, 4); n > 0; n--)
				rec_bytes.insert(rec_bytes.size(), rb());
		end else if (r < 28) begin
			for (n = $urandom_range(3, 12); n > 0; n--)
				rec_bytes.insert(rec_bytes.size(), rb());
		end else begin
			add16(16'($urandom_range(0, 65535)));
			add_labels($urandom_range(0, 2));
			rec_bytes.insert(rec_bytes.size(), 8'h00);
			long_tail = ($urandom_range(0, 9) == 0);
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				add_param(long_tail && i == n - 1);
		end
		keep = rec_bytes.size();
		if (r >= 28 && !long_tail && $urandom_range(0, 4) == 0)
			keep = $urandom_range(1, rec_bytes.size());
		flush_record(keep);
	endtask

	always @(negedge clk) begin
		beat_t bt;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_beats.size() > 0 && !take_idle()) begin
					bt = pending_beats.pop_front();
					in_valid <= 1'b1;
					data_byte <= bt.data;
					last <= bt.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !take_idle();
		end
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n)
			cycle_cnt++;
		in_taken = in_valid && in_ready;
		if (in_taken)
			parse_byte(data_byte, last);
		if (out_valid && out_ready) begin
			checked_cnt++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: kind %0d key %0h value %0h", kind, param_key, value);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (kind == svcbp_pkg::KIND_END)
					end_cnt++;
				if (kind !== exp_r.kind) begin
					$error("kind: expected %0d, got %0d", exp_r.kind, kind);
					errors++;
				end
				if (param_key !== exp_r.key) begin
					$error("param_key: expected %0h, got %0h", exp_r.key, param_key);
					errors++;
				end
				if (value !== exp_r.value) begin
					$error("value: expected %0h, got %0h", exp_r.value, value);
					errors++;
				end
				if (addr_high !== exp_r.hi) begin
					$error("addr_high: expected %0h, got %0h", exp_r.hi, addr_high);
					errors++;
				end
				if (addr_low !== exp_r.lo) begin
					$error("addr_low: expected %0h, got %0h", exp_r.lo, addr_low);
					errors++;
				end
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					errors++;
				end
				if (run_last !== exp_r.run_last) begin
					$error("run_last: expected %0d, got %0d", exp_r.run_last, run_last);
					errors++;
				end
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				stall = 0;
			else
				stall++;
		end
		$display("timeout after %0d cycles without a beat", STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		clear_parser();

		rec_bytes = '{8'hFF};
		flush_record(1);
		rec_bytes = '{8'h00, 8'hFF, 8'hC0};
		flush_record(3);
		rec_bytes = '{8'hFF, 8'hFF, 8'h00,
			8'h00, 8'h01, 8'h00, 8'h04, 8'h02, 8'hFF, 8'h00, 8'h05,
			8'h00, 8'h04, 8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		flush_record(19);
		rec_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00};
		flush_record(7);

		while (beat_cnt < RANDOM_BEATS)
			add_record();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d records in %0d bytes over %0d cycles", record_cnt, beat_cnt, cycle_cnt);
		$display("checked %0d results, %0d of them record ends", checked_cnt, end_cnt);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
src/svcbp_pkg.sv
src/svcbp_core.sv
src/svcb_rdata_param_parser.sv
src/svcbp_checker.sv
test/testbench.sv
